[rtl/swm_pkg.sv]
// Sliding window median: shared types and constants.
// Used by swm_cell and sliding_window_median; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

    // Width and reset value of the window size register.
    localparam int CFG_BITS = 7;
    localparam logic [CFG_BITS-1:0] WINDOW_SIZE_RST = 7'd3;

    // Operation broadcast along the cell chain.
    typedef struct packed {
        logic ins;  // insert the broadcast value in order
        logic rem;  // remove the first entry not below the broadcast value
    } t_cell_ctl;

endpackage

`default_nettype wire

[rtl/sliding_window_median.sv]
// Sliding window median filter, top level: sequencer, arrival ring, cell chain.
// Depends on swm_pkg and swm_cell.
//
// Usage
//   Input channel i_valid / o_stall carries i_sample (signed) and i_restart.
//   Output channel o_valid / i_stall carries o_median_x2, twice the median of
//   the last k samples (sum of the two middle values for even k).
//   Config channel i_cfg_valid / o_cfg_ready writes the window size k;
//   0 acts as 1, values above WINDOW_MAX act as WINDOW_MAX. Reset value 3.
//   Write it only while the block is idle.
// Sequence
//   While the window fills an item is inserted and checked and gives no result.
//   With the window full it goes on to median capture, output load and
//   removal of the oldest sample. Each extra sample dropped after k is lowered
//   adds another check and removal. The sequencer runs one chain operation
//   (insert or remove) at a time, reads the oldest sample from the registered
//   ring port and takes no new sample until it is back in idle.
// Reset and stall
//   Reset empties the window, clears the output valid flag and sets k to 3.
//   An output stall holds the result in the output register; the next item
//   is still taken and processed up to the point of loading its result.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_median #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // sample channel
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire signed [SAMPLE_BITS-1:0] i_sample,
    input  wire                          i_restart,
    // result channel
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic signed [SAMPLE_BITS:0]  o_median_x2,
    // window size register
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire [swm_pkg::CFG_BITS-1:0]  i_cfg_data
);
    import swm_pkg::*;

    localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int KW = $clog2(WINDOW_MAX + 1);
    localparam int SW = KW + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_CHK,
        S_OUT,
        S_DROP
    } t_state;

    t_state                        r_state;
    logic [CFG_BITS-1:0]           r_window_size;
    logic [KW-1:0]                 r_fill;
    logic [IW-1:0]                 r_head;
    logic                          r_final;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS:0]   r_med;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic                          r_restart;
    logic signed [SAMPLE_BITS-1:0] r_lo;
    logic signed [SAMPLE_BITS-1:0] r_hi;

    logic signed [SAMPLE_BITS-1:0] r_ring [WINDOW_MAX];
    logic signed [SAMPLE_BITS-1:0] r_ring_q;

    logic [KW-1:0]                 w_k;
    logic [IW-1:0]                 w_lo_idx;
    logic [IW-1:0]                 w_hi_idx;
    logic [KW-1:0]                 w_fill_eff;
    logic [IW-1:0]                 w_head_eff;
    logic [SW-1:0]                 w_sum;
    logic [IW-1:0]                 w_wr_addr;
    logic [IW-1:0]                 w_head_inc;
    logic                          w_out_free;
    t_cell_ctl                     w_ctl;
    logic [KW-1:0]                 w_count;
    logic signed [SAMPLE_BITS-1:0] w_bcast;

    logic signed [SAMPLE_BITS-1:0] w_cell_val [WINDOW_MAX];
    logic                          w_cell_gt  [WINDOW_MAX];

    // effective window size
    always_comb begin
        if (r_window_size == '0) begin
            w_k = KW'(1);
        end else if (32'(r_window_size) > 32'(WINDOW_MAX)) begin
            w_k = KW'(WINDOW_MAX);
        end else begin
            w_k = KW'(r_window_size);
        end
    end

    assign w_lo_idx = IW'((w_k - KW'(1)) >> 1);
    assign w_hi_idx = IW'(w_k >> 1);

    assign w_fill_eff = r_restart ? '0 : r_fill;
    assign w_head_eff = r_restart ? '0 : r_head;
    assign w_sum      = SW'(w_head_eff) + SW'(w_fill_eff);
    assign w_wr_addr  = (w_sum >= SW'(WINDOW_MAX)) ? IW'(w_sum - SW'(WINDOW_MAX))
                                                   : IW'(w_sum);
    assign w_head_inc = (32'(r_head) == WINDOW_MAX - 1) ? '0 : r_head + IW'(1);

    assign w_out_free  = !r_out_valid || !i_stall;
    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_median_x2 = r_med;
    assign o_cfg_ready = 1'b1;

    // chain operation of this cycle
    always_comb begin
        w_ctl.ins = (r_state == S_INS);
        w_ctl.rem = (r_state == S_DROP);
        w_count   = (r_state == S_INS) ? w_fill_eff : r_fill;
        w_bcast   = (r_state == S_INS) ? r_sample : r_ring_q;
    end

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
            logic signed [SAMPLE_BITS-1:0] w_left_val;
            logic                          w_left_gt;
            logic signed [SAMPLE_BITS-1:0] w_right_val;

            if (gi == 0) begin : g_first
                assign w_left_val = '0;
                assign w_left_gt  = 1'b0;
            end else begin : g_mid
                assign w_left_val = w_cell_val[gi-1];
                assign w_left_gt  = w_cell_gt[gi-1];
            end

            if (gi == WINDOW_MAX - 1) begin : g_last
                assign w_right_val = w_cell_val[gi];
            end else begin : g_inner
                assign w_right_val = w_cell_val[gi+1];
            end

            swm_cell #(
                .IDX         (gi),
                .SAMPLE_BITS (SAMPLE_BITS),
                .CNT_BITS    (KW)
            ) u_cell (
                .i_clk         (i_clk),
                .i_ctl         (w_ctl),
                .i_count       (w_count),
                .i_value       (w_bcast),
                .i_left_value  (w_left_val),
                .i_left_gt     (w_left_gt),
                .i_right_value (w_right_val),
                .o_value       (w_cell_val[gi]),
                .o_gt          (w_cell_gt[gi])
            );
        end
    endgenerate

    // arrival ring: one write port, one registered read port at the head
    always_ff @(posedge i_clk) begin
        if (r_state == S_INS) begin
            r_ring[w_wr_addr] <= r_sample;
        end
        r_ring_q <= r_ring[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_window_size <= WINDOW_SIZE_RST;
            r_fill        <= '0;
            r_head        <= '0;
            r_final       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_window_size <= i_cfg_data;
            end
            // in S_OUT the load below decides the flag
            if (r_out_valid && !i_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_sample  <= i_sample;
                        r_restart <= i_restart;
                        r_state   <= S_INS;
                    end
                end
                S_INS: begin
                    r_fill  <= w_fill_eff + KW'(1);
                    r_head  <= w_head_eff;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    // ring read of the head lands at the end of this cycle
                    if (r_fill > w_k) begin
                        r_final <= 1'b0;
                        r_state <= S_DROP;
                    end else if (r_fill < w_k) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_lo    <= w_cell_val[w_lo_idx];
                        r_hi    <= w_cell_val[w_hi_idx];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_med       <= {r_lo[SAMPLE_BITS-1], r_lo}
                                     + {r_hi[SAMPLE_BITS-1], r_hi};
                        r_out_valid <= 1'b1;
                        r_final     <= 1'b1;
                        r_state     <= S_DROP;
                    end
                end
                S_DROP: begin
                    r_fill  <= r_fill - KW'(1);
                    r_head  <= w_head_inc;
                    r_state <= r_final ? S_IDLE : S_CHK;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // window never holds more than the chain can
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= WINDOW_MAX)
        else $error("fill count above window capacity");

    // a result is only formed from a window of exactly k entries
    a_out_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (r_fill == w_k))
        else $error("median taken from a window not of size k");

    // removal needs a sample to remove
    a_drop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DROP) |-> (r_fill != '0))
        else $error("removal from an empty window");

    // a result appears only after the output state loads it
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("result raised outside the output state");

endmodule

`default_nettype wire

[rtl/swm_cell.sv]
// One cell of the sorted window chain: holds a single sorted entry.
// Depends on swm_pkg (t_cell_ctl).
`timescale 1ns / 1ps
`default_nettype none

module swm_cell #(
    parameter int IDX         = 0,
    parameter int SAMPLE_BITS = 16,
    parameter int CNT_BITS    = 7
) (
    input  wire                          i_clk,
    input  swm_pkg::t_cell_ctl           i_ctl,
    input  wire        [CNT_BITS-1:0]    i_count,
    input  wire signed [SAMPLE_BITS-1:0] i_value,
    input  wire signed [SAMPLE_BITS-1:0] i_left_value,
    input  wire                          i_left_gt,
    input  wire signed [SAMPLE_BITS-1:0] i_right_value,
    output logic signed [SAMPLE_BITS-1:0] o_value,
    output logic                         o_gt
);
    import swm_pkg::*;

    logic signed [SAMPLE_BITS-1:0] r_value;
    logic signed [SAMPLE_BITS-1:0] n_value;
    logic                          w_valid;
    logic                          w_ge;

    // entries at or beyond the count are empty and sort above everything
    assign w_valid = (32'(IDX) < 32'(i_count));
    assign o_gt    = !w_valid || (r_value > i_value);
    assign w_ge    = !w_valid || (r_value >= i_value);
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        if (i_ctl.ins) begin
            // entries above the new value move one place up
            if (i_left_gt) begin
                n_value = i_left_value;
            end else if (o_gt) begin
                n_value = i_value;
            end
        end else if (i_ctl.rem) begin
            // first entry >= value is the match; it and all above shift down
            if (w_ge) begin
                n_value = i_right_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

`default_nettype wire

[bench/tb_sliding_window_median.sv]
// Self-checking testbench for sliding_window_median: a directed burst, then random phases
// over a range of window sizes and idling mixes. It holds its own running-median predictor.
// Depends on swm_pkg and the sliding_window_median RTL only.
`timescale 1ns / 1ps

module tb_sliding_window_median;

    localparam int WINDOW_MAX    = 64;
    localparam int SAMPLE_BITS   = 16;
    localparam int SETTLE_CYCLES = 200;     // worst case: 63 extra drops
    localparam int CYCLE_LIMIT   = 500000;
    localparam int N_PHASES      = 12;
    localparam int N_DIRECTED    = 22;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    // Running-median predictor and the queue of medians still owed by the block.
    class t_median_scoreboard;
        logic signed [SAMPLE_BITS-1:0] arrival[WINDOW_MAX];
        logic signed [SAMPLE_BITS-1:0] ordered[WINDOW_MAX];
        int unsigned                   fill;
        int unsigned                   head;
        logic [swm_pkg::CFG_BITS-1:0]  window_size;
        logic signed [SAMPLE_BITS:0]   median_q[$];
        int                            samples_in;
        int                            medians_ok;
        int                            mismatches;

        function new();
            window_size = swm_pkg::WINDOW_SIZE_RST;
            fill        = 0;
            head        = 0;
            samples_in  = 0;
            medians_ok  = 0;
            mismatches  = 0;
            foreach (arrival[i]) begin
                arrival[i] = '0;
                ordered[i] = '0;
            end
        endfunction

        // Zero acts as one, oversize saturates.
        function int unsigned span();
            if (window_size == 0) return 1;
            if (window_size > WINDOW_MAX) return WINDOW_MAX;
            return 32'(window_size);
        endfunction

        function void retire_oldest();
            logic signed [SAMPLE_BITS-1:0] v;
            int unsigned                   pos;
            if (fill == 0) return;
            v   = arrival[head];
            pos = 0;
            while (pos < fill && ordered[pos] != v) pos++;
            for (int unsigned j = pos; j + 1 < fill; j++) ordered[j] = ordered[j+1];
            fill--;
            head = (head + 1) % WINDOW_MAX;
        endfunction

        function void note_sample(logic signed [SAMPLE_BITS-1:0] s, logic rs);
            int unsigned                 k;
            int unsigned                 pos;
            logic signed [SAMPLE_BITS:0] lo;
            logic signed [SAMPLE_BITS:0] hi;
            k = span();
            samples_in++;
            if (rs) begin
                fill = 0;
                head = 0;
            end
            arrival[(head + fill) % WINDOW_MAX] = s;
            pos = 0;
            while (pos < fill && ordered[pos] <= s) pos++;
            for (int unsigned j = fill; j > pos; j--) ordered[j] = ordered[j-1];
            ordered[pos] = s;
            fill++;
            // window may have shrunk since the last item
            while (fill > k) retire_oldest();
            if (fill < k) return;
            lo = (SAMPLE_BITS + 1)'(ordered[(k - 1) / 2]);
            hi = (SAMPLE_BITS + 1)'(ordered[k / 2]);
            median_q.insert(median_q.size(), lo + hi);
            retire_oldest();
        endfunction

        function void check_median(logic signed [SAMPLE_BITS:0] got);
            logic signed [SAMPLE_BITS:0] want;
            if (median_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected median %0d with nothing pending", $time, got);
                return;
            end
            want = median_q.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: median mismatch, expected %0d got %0d", $time, want, got);
            end else begin
                medians_ok++;
            end
        endfunction
    endclass

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_valid     = 1'b0;
    logic signed [SAMPLE_BITS-1:0] i_sample    = '0;
    logic                          i_restart   = 1'b0;
    logic                          i_stall     = 1'b0;
    logic                          i_cfg_valid = 1'b0;
    logic [swm_pkg::CFG_BITS-1:0]  i_cfg_data  = '0;
    wire                           o_stall;
    wire                           o_valid;
    wire signed [SAMPLE_BITS:0]    o_median_x2;
    wire                           o_cfg_ready;

    t_median_scoreboard sb = new();
    int                 idle_pct  = 0;
    int                 stall_pct = 0;
    int                 settings  = 0;
    int                 cycle_count;

    sliding_window_median #(
        .WINDOW_MAX (WINDOW_MAX),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_sample   (i_sample),
        .i_restart  (i_restart),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_median_x2(o_median_x2),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_median(o_median_x2);
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic rs);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_sample  <= s;
        i_restart <= rs;
        do @(posedge i_clk); while (o_stall);
        sb.note_sample(s, rs);
    endtask

    // Let every owed median out, then give the sequencer time to finish any drops.
    task automatic settle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.median_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window_size(input logic [swm_pkg::CFG_BITS-1:0] v);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.window_size = v;
        settings++;
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
        case ($urandom_range(7))
            0: begin
                case ($urandom_range(3))
                    0: return 16'sh7FFF;
                    1: return 16'sh8000;
                    2: return 16'sh0000;
                    default: return 16'shFFFF;
                endcase
            end
            1, 2: return 16'($urandom_range(8) - 4);    // ties
            3, 4: return 16'($urandom);
            default: return 16'($urandom_range(2000) - 1000);
        endcase
    endfunction

    // Directed burst at the reset window size of three.
    logic signed [SAMPLE_BITS-1:0] dir_s[N_DIRECTED] = '{
        32767, -32768, 0, -1, 32767, 32767, 32767, 32767, -32768, -32768, -32768,
        7, 7, 7, 7, 100, -100, 3, 3, -3, 0, 1
    };
    logic dir_r[N_DIRECTED] = '{
        1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
        0, 0, 0, 1, 0, 0, 1, 0, 0, 0, 0
    };

    // 64 then 4 shrinks a filled window; 2 then 5 grows one; 0 and 127 hit the edges.
    int phase_k[N_PHASES] = '{1, 0, 2, 5, 64, 4, 127, 65, 7, 2, 1, 33};
    int phase_n[N_PHASES] = '{150, 150, 150, 150, 250, 150, 250, 200, 150, 100, 150, 150};

    initial begin
        t_idle_mode  mode;
        int unsigned k_eff;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_s[i]) send_sample(dir_s[i], dir_r[i]);

        phase_k[10] = $urandom_range(20, 1);
        for (int p = 0; p < N_PHASES; p++) begin
            mode = t_idle_mode'(p % 4);
            write_window_size(phase_k[p][swm_pkg::CFG_BITS-1:0]);
            idle_pct  = (mode == IDLE_SENDER)   ? 54 : (mode == IDLE_BOTH) ? 24 : 0;
            stall_pct = (mode == IDLE_RECEIVER) ? 54 : (mode == IDLE_BOTH) ? 24 : 0;
            k_eff = sb.span();
            repeat (phase_n[p])
                send_sample(random_sample(), $urandom_range(4 * k_eff + 16) == 0);
        end
        settle();

        $display("%0d samples over %0d window settings, %0d medians matched in %0d cycles",
                 sb.samples_in, settings, sb.medians_ok, cycle_count);
        $display("%0d mismatches, %0d medians never seen", sb.mismatches, sb.median_q.size());
        if (sb.mismatches == 0 && sb.median_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
